// ===== sv/fmpm_pkg.sv =====
`default_nettype none
package fmpm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned STEP_W   = 31;
  localparam int unsigned PROD_W   = 48;
  localparam int unsigned INC_W    = 32;
  localparam int unsigned FRAC_SH  = 15;

  localparam logic [STEP_W-1:0] STEP_RESET = 31'd21474836;

  localparam logic [63:0] AMP_SCALE   = 64'd22937;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] HALF_Q30    = 64'd1 << 29;

  // APB register map, one word per register
  typedef enum logic {
    REG_DEVIATION_STEP = 1'b0
  } reg_idx_t;

  // Unsigned long division, used only while building the table at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry k of 2**abits, scaled to AMP_SCALE, Q30 Taylor series
  function automatic logic [AMP_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] scaled;
    logic [63:0] den;
    x = (64'(k) * HALF_PI_Q30) >> abits;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int unsigned i = 1; i <= 8; i++) begin
      den = 64'(2 * i) * 64'(2 * i + 1);
      term = udiv64((term * x2) >> 30, den);
      if (i[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    scaled = (sum * AMP_SCALE + HALF_Q30) >> 30;
    if (scaled > AMP_SCALE) begin
      scaled = AMP_SCALE;
    end
    return scaled[AMP_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/fmpm_cfg.sv =====
`default_nettype none
module fmpm_cfg
  import fmpm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [STEP_W-1:0] deviation_step
);

  reg_idx_t reg_idx;
  logic     in_map;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[2]);
  assign in_map  = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && in_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      deviation_step <= STEP_RESET;
    end else if (wr_en && reg_idx == REG_DEVIATION_STEP) begin
      deviation_step <= pwdata[STEP_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEVIATION_STEP: prdata = {1'b0, deviation_step};
      default:            prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/fmpm_nco.sv =====
`default_nettype none
module fmpm_nco
  import fmpm_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic        [STEP_W-1:0]   deviation_step,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic             [PHASE_BITS-1:0] out_phase,
  output logic                            out_last
);

  localparam int unsigned EXT_W = (PHASE_BITS > INC_W) ? PHASE_BITS : INC_W;

  // input register
  logic                       v0;
  logic signed [SAMPLE_W-1:0] smp0;
  logic                       last0;
  // product register
  logic                       v1;
  logic signed [PROD_W-1:0]   prod1;
  logic                       last1;

  logic                       rdy0;
  logic                       rdy1;
  logic                       rdy2;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [INC_W-1:0]    inc;
  logic signed [EXT_W-1:0]    inc_ext;
  logic        [PHASE_BITS-1:0] phase_next;

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  assign prod_next = $signed({1'b0, deviation_step}) * PROD_W'(smp0);
  // arithmetic shift rounds toward minus infinity
  assign inc        = prod1[INC_W+FRAC_SH-1:FRAC_SH];
  assign inc_ext    = EXT_W'(inc);
  assign phase_next = out_phase + inc_ext[PHASE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      out_valid <= 1'b0;
      out_phase <= '0;
    end else begin
      if (rdy0) begin
        v0 <= in_valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        out_valid <= v1;
      end
      // advance the accumulator once per transfer into the phase stage
      if (rdy2 && v1) begin
        out_phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      smp0  <= in_sample;
      last0 <= in_last;
    end
    if (rdy1 && v0) begin
      prod1 <= prod_next;
      last1 <= last0;
    end
    if (rdy2 && v1) begin
      out_last <= last1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fmpm_rom.sv =====
`default_nettype none
module fmpm_rom
  import fmpm_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [ADDR_BITS:0]   addr_a,
  input  wire logic [ADDR_BITS:0]   addr_b,
  output logic      [AMP_W-1:0]     data_a,
  output logic      [AMP_W-1:0]     data_b
);

  localparam int unsigned DEPTH = (1 << ADDR_BITS) + 1;

  typedef logic [AMP_W-1:0] rom_arr_t [DEPTH];

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    for (int unsigned k = 0; k < DEPTH; k++) begin
      r[k] = sine_entry(k, ADDR_BITS);
    end
    return r;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= ROM[addr_a];
      data_b <= ROM[addr_b];
    end
  end

endmodule
`default_nettype wire

// ===== sv/fmpm_sincos.sv =====
`default_nettype none
module fmpm_sincos
  import fmpm_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [PHASE_BITS-1:0]   in_phase,
  input  wire logic                    in_last,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      i_out,
  output logic signed [OUT_W-1:0]      q_out,
  output logic                         last_out
);

  localparam int unsigned A = TABLE_ADDR_BITS;
  localparam logic [A:0]  N_IDX = (A+1)'(1 << A);

  logic [A+1:0]     idx;
  logic [1:0]       quad;
  logic [A:0]       k;
  logic [A:0]       k_rev;
  logic [A:0]       addr_sin;
  logic [A:0]       addr_cos;
  logic [AMP_W-1:0] sin_mag;
  logic [AMP_W-1:0] cos_mag;

  logic v3;
  logic neg_sin3;
  logic neg_cos3;
  logic last3;
  logic rdy3;
  logic rdy4;
  logic ld3;
  logic ld4;

  assign idx   = in_phase[PHASE_BITS-1 -: A+2];
  assign quad  = idx[A+1:A];
  assign k     = {1'b0, idx[A-1:0]};
  assign k_rev = N_IDX - k;
  // odd quadrants read the table backwards; cosine sits one quadrant ahead
  assign addr_sin = quad[0] ? k_rev : k;
  assign addr_cos = quad[0] ? k : k_rev;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign in_ready = rdy3;
  assign ld3      = rdy3 && in_valid;
  assign ld4      = rdy4 && v3;

  fmpm_rom #(
    .ADDR_BITS(A)
  ) u_rom (
    .clk    (clk),
    .en     (ld3),
    .addr_a (addr_sin),
    .addr_b (addr_cos),
    .data_a (sin_mag),
    .data_b (cos_mag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy3) begin
        v3 <= in_valid;
      end
      if (rdy4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      neg_sin3 <= quad[1];
      neg_cos3 <= quad[1] ^ quad[0];
      last3    <= in_last;
    end
    if (ld4) begin
      i_out    <= neg_cos3 ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
      q_out    <= neg_sin3 ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      last_out <= last3;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fm_phase_modulator.sv =====
// FM modulator: phase accumulator driven by scaled samples, quarter-wave sin/cos table.
// Path: each sample passes the input, product, phase, table read and output registers to m_tvalid.
// Throughput: one sample per cycle while m_tready does not stall the output; the loop is the phase addition.
// Stages: input register, multiplier, accumulator, table read, output register.
// Reset (rst, synchronous): pipeline emptied, phase cleared, deviation_step to 21474836.
`default_nettype none
module fm_phase_modulator
  import fmpm_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // samples in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] pcm_sample
  input  wire logic        s_tlast,
  // I/Q out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] i_out, [31:16] q_out
  output logic             m_tlast
);

  logic [STEP_W-1:0]      deviation_step;
  logic                   ph_valid;
  logic                   ph_ready;
  logic [PHASE_BITS-1:0]  ph_phase;
  logic                   ph_last;
  logic signed [OUT_W-1:0] i_out;
  logic signed [OUT_W-1:0] q_out;

  fmpm_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .deviation_step (deviation_step)
  );

  fmpm_nco #(
    .PHASE_BITS(PHASE_BITS)
  ) u_nco (
    .clk            (clk),
    .rst            (rst),
    .deviation_step (deviation_step),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_sample      (s_tdata[SAMPLE_W-1:0]),
    .in_last        (s_tlast),
    .out_valid      (ph_valid),
    .out_ready      (ph_ready),
    .out_phase      (ph_phase),
    .out_last       (ph_last)
  );

  fmpm_sincos #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_sincos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ph_valid),
    .in_ready  (ph_ready),
    .in_phase  (ph_phase),
    .in_last   (ph_last),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .i_out     (i_out),
    .q_out     (q_out),
    .last_out  (m_tlast)
  );

  assign m_tdata = {q_out, i_out};

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb
  import fmpm_pkg::*;
();

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int PIPE_LATENCY  = 4;
  localparam int IDLE_LIMIT    = 4000;
  localparam int PHASE_ITEMS   = 385;

  localparam int QUARTER       = 1024;
  localparam int ADDR_SHIFT    = 10;
  localparam logic [63:0] AMPLITUDE   = 64'd22937;
  localparam logic [63:0] QUARTER_Q30 = 64'd1686629713;
  localparam logic [63:0] ROUND_Q30   = 64'd1 << 29;

  localparam logic [2:0]  STEP_ADDR   = {REG_DEVIATION_STEP, 2'b00};
  localparam logic [2:0]  SPARE_ADDR  = 3'd4;   // one past the register map
  localparam logic [30:0] STEP_MAX    = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [15:0] i_val;
    logic signed [15:0] q_val;
    logic               frame_end;
  } iq_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] pcm_sample
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // [15:0] i_out, [31:16] q_out
  logic        m_tlast;

  fm_phase_modulator dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Modulator state as the testbench sees it
  int          quarter_sine [0:QUARTER];
  logic [30:0] step_model;
  logic [31:0] phase_model;
  iq_t         pending_iq [$];

  int errors;
  int idle_cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;

  function automatic int taylor_entry(input int k);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] amp;
    ang  = (64'(k) * QUARTER_Q30) >> ADDR_SHIFT;
    ang2 = (ang * ang) >> 30;
    term = ang;
    acc  = ang;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    amp = (acc * AMPLITUDE + ROUND_Q30) >> 30;
    if (amp > AMPLITUDE) begin
      amp = AMPLITUDE;
    end
    return int'(amp);
  endfunction

  function automatic logic signed [15:0] sine_at(input logic [11:0] idx);
    int mag;
    if (idx[10]) begin
      mag = quarter_sine[QUARTER - int'(idx[9:0])];
    end else begin
      mag = quarter_sine[int'(idx[9:0])];
    end
    return idx[11] ? 16'(-mag) : 16'(mag);
  endfunction

  // Advance the phase by one sample and return the I/Q pair at the new phase
  function automatic iq_t modulate(input logic signed [15:0] smp, input logic lst);
    logic signed [47:0] prod;
    logic signed [47:0] inc;
    logic [11:0]        idx;
    iq_t                r;
    prod = $signed({17'd0, step_model}) * smp;
    inc  = prod >>> 15;
    phase_model = phase_model + inc[31:0];
    idx = phase_model[31:20];
    r.i_val = sine_at(idx + 12'd1024);
    r.q_val = sine_at(idx);
    r.frame_end = lst;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    iq_t want;
    if (m_tvalid && m_tready) begin
      if (pending_iq.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: i=%0d q=%0d last=%0b", $time,
                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast);
      end else begin
        want = pending_iq.pop_front();
        if ($signed(m_tdata[15:0]) != want.i_val) begin
          errors++;
          $display("%0t: i_out expected %0d actual %0d", $time, want.i_val,
                   $signed(m_tdata[15:0]));
        end
        if ($signed(m_tdata[31:16]) != want.q_val) begin
          errors++;
          $display("%0t: q_out expected %0d actual %0d", $time, want.q_val,
                   $signed(m_tdata[31:16]));
        end
        if (m_tlast != want.frame_end) begin
          errors++;
          $display("%0t: last_out expected %0b actual %0b", $time, want.frame_end, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [15:0] smp, input logic lst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_iq.push_back(modulate(smp, lst));
  endtask

  // Hold the input until every result is in, then let the pipeline empty
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_iq.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == STEP_ADDR) begin
      step_model = value[30:0];
    end
    @(negedge clk);
    // read back the register while the address is still held
    if (addr == STEP_ADDR && prdata != {1'b0, step_model}) begin
      errors++;
      $display("%0t: prdata expected %0h actual %0h", $time, {1'b0, step_model}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1, 2:    return 16'($signed(17'($urandom_range(512))) - 17'sd256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_full_scale_samples();
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(-16'sh0001, 1'b0);
    send_sample(16'sh4000, 1'b0);
    send_sample(-16'sh4000, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    wait_for_results();
  endtask

  task automatic test_step_limits();
    write_reg(STEP_ADDR, 32'd0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0005, 1'b0);
    wait_for_results();
    write_reg(STEP_ADDR, {1'b0, STEP_MAX});
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(-16'sh0001, 1'b1);
    wait_for_results();
  endtask

  task automatic test_register_map();
    // bit 31 lies above the register and must be dropped
    write_reg(STEP_ADDR, 32'hFFFF_FFFF);
    send_sample(16'sh2345, 1'b0);
    send_sample(16'shC001, 1'b1);
    wait_for_results();
    write_reg(SPARE_ADDR, 32'h0000_0000);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh1234, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input logic [30:0] step, input int s_pct,
                                     input int r_pct, input bit hold_midway);
    write_reg(STEP_ADDR, {1'b0, step});
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (hold_midway && n == PHASE_ITEMS / 2) begin
        wait_for_results();
      end
      send_sample(pick_sample(), ($urandom_range(7) == 0));
    end
    wait_for_results();
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    step_model     = STEP_RESET;
    phase_model    = '0;
    for (int k = 0; k <= QUARTER; k++) begin
      quarter_sine[k] = taylor_entry(k);
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_full_scale_samples();
    test_step_limits();
    test_register_map();
    test_random_traffic(31'($urandom), 0, 0, 1'b0);
    test_random_traffic(STEP_MAX, 82, 0, 1'b1);
    test_random_traffic(31'($urandom_range(65536)), 0, 82, 1'b0);
    test_random_traffic(31'($urandom), 23, 23, 1'b0);

    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
sv/fmpm_pkg.sv
sv/fmpm_cfg.sv
sv/fmpm_nco.sv
sv/fmpm_rom.sv
sv/fmpm_sincos.sv
sv/fm_phase_modulator.sv
tb/sv/tb.sv
